FILE: rtl/core/rhsp_pkg.sv
// rhsp_pkg: shared types and constants of the rtsp header stream parser
// holds the classified input word, the result word and the field widths
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rhsp_pkg;

	localparam int VER_W = 8;
	localparam int LEN_W = 32;

	// byte roles
	localparam logic [2:0] ROLE_NONE    = 3'd0;
	localparam logic [2:0] ROLE_METHOD  = 3'd1;
	localparam logic [2:0] ROLE_URI     = 3'd2;
	localparam logic [2:0] ROLE_REASON  = 3'd3;
	localparam logic [2:0] ROLE_NAME    = 3'd4;
	localparam logic [2:0] ROLE_VALUE   = 3'd5;
	localparam logic [2:0] ROLE_CONTENT = 3'd6;

	// message kinds
	localparam logic [1:0] KIND_UNKNOWN  = 2'd0;
	localparam logic [1:0] KIND_REQUEST  = 2'd1;
	localparam logic [1:0] KIND_RESPONSE = 2'd2;

	// chunk status codes
	localparam logic [1:0] STAT_NONE       = 2'd0;
	localparam logic [1:0] STAT_DONE       = 2'd1;
	localparam logic [1:0] STAT_INCOMPLETE = 2'd2;
	localparam logic [1:0] STAT_ERROR      = 2'd3;

	// classified input word
	typedef struct packed {
		logic [7:0] data;
		logic [7:0] low;
		logic       last;
		logic       tok;
		logic       dig;
		logic       ctl;
	} word_t;

	// front queue head as seen by the back end
	typedef struct packed {
		logic  valid;
		word_t word;
	} fq_t;

	// result word
	typedef struct packed {
		logic [7:0]       out_byte;
		logic [2:0]       byte_role;
		logic [1:0]       message_kind;
		logic [VER_W-1:0] major_version;
		logic [VER_W-1:0] minor_version;
		logic [LEN_W-1:0] body_length;
		logic [LEN_W-1:0] body_received;
		logic [1:0]       chunk_status;
	} res_t;

endpackage
`default_nettype wire

FILE: rtl/core/rhsp_front.sv
// rhsp_front: classifies each incoming byte and holds it in a 4-word queue
// depends on rhsp_pkg
`timescale 1ns / 1ps
`default_nettype none
module rhsp_front import rhsp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] data_byte,
	input  wire logic       chunk_end,
	input  wire logic       push,
	output logic            full,
	output fq_t             fq,
	input  wire logic       take
);

	word_t      mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic       wr_en;
	word_t      cw;

	// byte classification
	always_comb begin
		cw.data = data_byte;
		cw.last = chunk_end;
		cw.low  = (data_byte >= 8'h41 && data_byte <= 8'h5a) ? data_byte + 8'd32 : data_byte;
		cw.ctl  = (data_byte <= 8'd31) || (data_byte == 8'd127);
		cw.dig  = (data_byte >= 8'h30) && (data_byte <= 8'h39);
		cw.tok  = !(data_byte > 8'd127 || cw.ctl);
		unique case (data_byte)
			8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a, 8'h5c, 8'h22,
			8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d, 8'h20, 8'h09: cw.tok = 1'b0;
			default: ;
		endcase
	end

	assign full     = (cnt_q == 3'd4);
	assign wr_en    = push && !full;
	assign fq.valid = (cnt_q != 3'd0);
	assign fq.word  = mem_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q] <= cw;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wr_q <= wr_q + 2'd1;
			if (take) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, wr_en} - {2'b0, take};
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'd4)
		else $error("front queue count out of range");
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n) take |-> fq.valid)
		else $error("back end took a word from an empty queue");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 3'd4 && !take) |=> cnt_q == 3'd4)
		else $error("full queue changed without a take");

endmodule
`default_nettype wire

FILE: rtl/core/rhsp_back.sv
// rhsp_back: message parser state machine and a 2-word result queue
// depends on rhsp_pkg
`timescale 1ns / 1ps
`default_nettype none
module rhsp_back import rhsp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  fq_t       fq,
	output logic      take,
	output res_t      res,
	output logic      empty,
	input  wire logic pop
);

	typedef enum logic [23:0] {
		PH_START     = 24'h000001, PH_METHOD   = 24'h000002, PH_URI      = 24'h000004,
		PH_REQ_PROTO = 24'h000008, PH_REQ_MAJ0 = 24'h000010, PH_REQ_MAJ  = 24'h000020,
		PH_REQ_MIN0  = 24'h000040, PH_REQ_MIN  = 24'h000080, PH_REQ_LF   = 24'h000100,
		PH_RSP_MAJ0  = 24'h000200, PH_RSP_MAJ  = 24'h000400, PH_RSP_MIN0 = 24'h000800,
		PH_RSP_MIN   = 24'h001000, PH_REASON   = 24'h002000, PH_RSP_LF   = 24'h004000,
		PH_HDR_START = 24'h008000, PH_HDR_NAME = 24'h010000, PH_HDR_SPACE = 24'h020000,
		PH_HDR_VALUE = 24'h040000, PH_HDR_LF   = 24'h080000, PH_END_LF   = 24'h100000,
		PH_CONTENT   = 24'h200000, PH_IGNORE   = 24'h400000, PH_DISCARD  = 24'h800000
	} phase_t;

	localparam logic [VER_W-1:0] VER_MAX = '1;
	localparam logic [LEN_W-1:0] LEN_MAX = '1;
	localparam logic [3:0]       NAME_LEN = 4'd14;

	// message registers
	phase_t           ph_q, ph_n;
	logic [2:0]       pre_q, pre_n;
	logic             tn_q, tn_n;
	logic [1:0]       kind_q, kind_n;
	logic [VER_W-1:0] maj_q, maj_n, min_q, min_n;
	logic [3:0]       pos_q, pos_n, pos_e;
	logic             nm_q, nm_n, nm_e, hit;
	logic             seen_q, seen_n;
	logic [1:0]       ldp_q, ldp_n;
	logic [LEN_W-1:0] len_q, len_n;
	logic [LEN_W-1:0] rcv_q, rcv_n;

	// result queue
	res_t       oq_q [2];
	logic       owr_q, ord_q;
	logic [1:0] ocnt_q;
	logic       pop_ok;
	res_t       r;
	word_t      w;
	logic [7:0] b, ob;
	logic [2:0] role;
	logic [1:0] stat;
	logic       restart;
	logic [3:0] d;

	function automatic logic [7:0] proto_chr(input logic [2:0] i);
		unique case (i)
			3'd0:    return 8'h52;
			3'd1:    return 8'h54;
			3'd2:    return 8'h53;
			3'd3:    return 8'h50;
			default: return 8'h2f;
		endcase
	endfunction

	function automatic logic [7:0] cl_chr(input logic [3:0] i);
		unique case (i)
			4'd0: return 8'h63;  4'd1: return 8'h6f;  4'd2: return 8'h6e;
			4'd3: return 8'h74;  4'd4: return 8'h65;  4'd5: return 8'h6e;
			4'd6: return 8'h74;  4'd7: return 8'h2d;  4'd8: return 8'h6c;
			4'd9: return 8'h65;  4'd10: return 8'h6e; 4'd11: return 8'h67;
			4'd12: return 8'h74; 4'd13: return 8'h68;
			default: return 8'h00;
		endcase
	endfunction

	// v*10+d with saturation
	function automatic logic [VER_W-1:0] acc_ver(input logic [VER_W-1:0] v,
			input logic [3:0] dd);
		logic [VER_W+3:0] t;
		t = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{VER_W{1'b0}}, dd};
		return (t > {4'b0, VER_MAX}) ? VER_MAX : t[VER_W-1:0];
	endfunction

	function automatic logic [LEN_W-1:0] acc_len(input logic [LEN_W-1:0] v,
			input logic [3:0] dd);
		logic [LEN_W+3:0] t;
		t = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{LEN_W{1'b0}}, dd};
		return (t > {4'b0, LEN_MAX}) ? LEN_MAX : t[LEN_W-1:0];
	endfunction

	assign pop_ok = pop && !empty;
	assign empty  = (ocnt_q == 2'd0);
	assign take   = fq.valid && (ocnt_q != 2'd2 || pop_ok);
	assign res    = oq_q[ord_q];
	assign w      = fq.word;
	assign b      = w.data;
	assign d      = b[3:0];

	// parse one word
	always_comb begin
		ph_n = ph_q; pre_n = pre_q; tn_n = tn_q; kind_n = kind_q;
		maj_n = maj_q; min_n = min_q; pos_n = pos_q; nm_n = nm_q;
		seen_n = seen_q; ldp_n = ldp_q; len_n = len_q; rcv_n = rcv_q;
		role = ROLE_NONE; ob = b; stat = STAT_NONE; restart = 1'b0;
		pos_e = pos_q; nm_e = nm_q; hit = 1'b0;
		unique case (ph_q)
			PH_START: begin
				if (pre_q < 3'd4 && b == proto_chr(pre_q)) pre_n = pre_q + 3'd1;
				else if (pre_q == 3'd4 && b == 8'h2f) ph_n = PH_RSP_MAJ0;
				else if (w.tok) begin
					ph_n = PH_METHOD; role = ROLE_METHOD;
				end else if (b == 8'h20 && pre_q != 3'd0) begin
					ph_n = PH_URI; tn_n = 1'b0;
				end else ph_n = PH_DISCARD;
			end
			PH_METHOD: begin
				if (w.tok) role = ROLE_METHOD;
				else if (b == 8'h20) begin
					ph_n = PH_URI; tn_n = 1'b0;
				end else ph_n = PH_DISCARD;
			end
			PH_URI: begin
				if (b == 8'h20) begin
					if (tn_q) begin
						ph_n = PH_REQ_PROTO; pre_n = 3'd0;
					end else ph_n = PH_DISCARD;
				end else if (!w.ctl) begin
					role = ROLE_URI; tn_n = 1'b1;
				end else ph_n = PH_DISCARD;
			end
			PH_REQ_PROTO: begin
				if (pre_q < 3'd5 && b == proto_chr(pre_q)) begin
					pre_n = pre_q + 3'd1;
					if (pre_q == 3'd4) ph_n = PH_REQ_MAJ0;
				end else ph_n = PH_DISCARD;
			end
			PH_REQ_MAJ0, PH_RSP_MAJ0: begin
				if (w.dig) begin
					maj_n = acc_ver(maj_q, d);
					ph_n  = (ph_q == PH_REQ_MAJ0) ? PH_REQ_MAJ : PH_RSP_MAJ;
				end else ph_n = PH_DISCARD;
			end
			PH_REQ_MAJ, PH_RSP_MAJ: begin
				if (w.dig) maj_n = acc_ver(maj_q, d);
				else if (b == 8'h2e) ph_n = (ph_q == PH_REQ_MAJ) ? PH_REQ_MIN0 : PH_RSP_MIN0;
				else ph_n = PH_DISCARD;
			end
			PH_REQ_MIN0, PH_RSP_MIN0: begin
				if (w.dig) begin
					min_n = acc_ver(min_q, d);
					ph_n  = (ph_q == PH_REQ_MIN0) ? PH_REQ_MIN : PH_RSP_MIN;
				end else ph_n = PH_DISCARD;
			end
			PH_REQ_MIN: begin
				if (w.dig) min_n = acc_ver(min_q, d);
				else if (b == 8'h0d) ph_n = PH_REQ_LF;
				else ph_n = PH_DISCARD;
			end
			PH_RSP_MIN: begin
				if (w.dig) min_n = acc_ver(min_q, d);
				else if (b == 8'h20) ph_n = PH_REASON;
				else ph_n = PH_DISCARD;
			end
			PH_REASON: begin
				if (b == 8'h0d) ph_n = PH_RSP_LF;
				else if (!w.ctl) role = ROLE_REASON;
				else ph_n = PH_DISCARD;
			end
			PH_REQ_LF, PH_RSP_LF, PH_HDR_LF: begin
				if (b == 8'h0a) begin
					if (ph_q == PH_REQ_LF) kind_n = KIND_REQUEST;
					else if (ph_q == PH_RSP_LF) kind_n = KIND_RESPONSE;
					ph_n = PH_HDR_START;
				end else ph_n = PH_DISCARD;
			end
			PH_HDR_START, PH_HDR_NAME: begin
				if (ph_q == PH_HDR_START && b == 8'h0d) ph_n = PH_END_LF;
				else if (ph_q == PH_HDR_START && !w.tok) ph_n = PH_DISCARD;
				else begin
					if (ph_q == PH_HDR_START) begin
						pos_e = 4'd0; nm_e = 1'b1; ph_n = PH_HDR_NAME;
					end
					pos_n = pos_e; nm_n = nm_e;
					if (w.tok) begin
						ob = w.low; role = ROLE_NAME;
						if (pos_e < NAME_LEN && w.low == cl_chr(pos_e)) pos_n = pos_e + 4'd1;
						else nm_n = 1'b0;
					end else if (b == 8'h3a) begin
						hit    = nm_e && pos_e == NAME_LEN;
						nm_n   = hit && !seen_q;
						seen_n = seen_q || hit;
						ph_n   = PH_HDR_SPACE;
					end else ph_n = PH_DISCARD;
				end
			end
			PH_HDR_SPACE: ph_n = (b == 8'h20) ? PH_HDR_VALUE : PH_DISCARD;
			PH_HDR_VALUE: begin
				if (b == 8'h0d) begin
					ph_n = PH_HDR_LF; nm_n = 1'b0;
				end else begin
					role = ROLE_VALUE;
					// content-length digits, atoi style
					if (nm_q) begin
						priority case (ldp_q)
							2'd0: begin
								if (b == 8'h20 || b == 8'h09 || b == 8'h0a || b == 8'h0b
										|| b == 8'h0c) ;
								else if (b == 8'h2b) ldp_n = 2'd1;
								else if (b == 8'h2d) ldp_n = 2'd2;
								else if (!w.dig) ldp_n = 2'd3;
								else begin
									ldp_n = 2'd1; len_n = acc_len(len_q, d);
								end
							end
							2'd3: ;
							default: begin
								if (!w.dig) ldp_n = 2'd3;
								else if (ldp_q == 2'd1) len_n = acc_len(len_q, d);
								else if (b != 8'h30 || len_q != '0) len_n = LEN_MAX;
							end
						endcase
					end
				end
			end
			PH_END_LF: begin
				if (b == 8'h0a) begin
					ph_n  = (len_q == '0) ? PH_IGNORE : PH_CONTENT;
					rcv_n = '0;
				end else ph_n = PH_DISCARD;
			end
			PH_CONTENT: begin
				role = ROLE_CONTENT;
				if (rcv_q != LEN_MAX) rcv_n = rcv_q + LEN_W'(1);
			end
			PH_IGNORE: ;
			default: ph_n = PH_DISCARD;
		endcase

		// chunk end report
		if (w.last) begin
			restart = 1'b1;
			if (ph_n == PH_CONTENT) begin
				if (rcv_n >= len_n) stat = STAT_DONE;
				else begin
					stat = STAT_INCOMPLETE; restart = 1'b0;
				end
			end else if (ph_n == PH_IGNORE) stat = STAT_DONE;
			else stat = STAT_ERROR;
		end

		r.out_byte      = ob;
		r.byte_role     = role;
		r.message_kind  = kind_n;
		r.major_version = maj_n;
		r.minor_version = min_n;
		r.body_length   = len_n;
		r.body_received = rcv_n;
		r.chunk_status  = stat;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_START; pre_q <= '0; tn_q <= 1'b0; kind_q <= KIND_UNKNOWN;
			maj_q <= '0; min_q <= '0; pos_q <= '0; nm_q <= 1'b1; seen_q <= 1'b0;
			ldp_q <= '0; len_q <= '0; rcv_q <= '0;
		end else if (take) begin
			if (restart) begin
				ph_q <= PH_START; pre_q <= '0; tn_q <= 1'b0; kind_q <= KIND_UNKNOWN;
				maj_q <= '0; min_q <= '0; pos_q <= '0; nm_q <= 1'b1; seen_q <= 1'b0;
				ldp_q <= '0; len_q <= '0; rcv_q <= '0;
			end else begin
				ph_q <= ph_n; pre_q <= pre_n; tn_q <= tn_n; kind_q <= kind_n;
				maj_q <= maj_n; min_q <= min_n; pos_q <= pos_n; nm_q <= nm_n;
				seen_q <= seen_n; ldp_q <= ldp_n; len_q <= len_n; rcv_q <= rcv_n;
			end
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (take) oq_q[owr_q] <= r;
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q <= 1'b0; ord_q <= 1'b0; ocnt_q <= '0;
		end else begin
			if (take) owr_q <= !owr_q;
			if (pop_ok) ord_q <= !ord_q;
			ocnt_q <= ocnt_q + {1'b0, take} - {1'b0, pop_ok};
		end
	end

	a_ocnt: assert property (@(posedge clk) disable iff (!arst_n) ocnt_q <= 2'd2)
		else $error("result queue count out of range");
	a_stat_last: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ((stat != STAT_NONE) == w.last))
		else $error("chunk status does not follow chunk end");
	a_incomplete: assert property (@(posedge clk) disable iff (!arst_n)
		(take && stat == STAT_INCOMPLETE) |=> ph_q == PH_CONTENT)
		else $error("incomplete chunk left the content phase");
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (stat == STAT_DONE || stat == STAT_ERROR)) |=>
		(ph_q == PH_START && kind_q == KIND_UNKNOWN && len_q == '0))
		else $error("message registers not cleared after chunk end");

endmodule
`default_nettype wire

FILE: rtl/core/rtsp_header_stream_parser.sv
// rtsp_header_stream_parser: top level of the rtsp header stream parser
// depends on rhsp_pkg, rhsp_front and rhsp_back
`timescale 1ns / 1ps
`default_nettype none
// Takes one message byte per word and returns one result word per byte, in
// order: the byte (lowercased in header names), its role, the message kind,
// versions, content length, content bytes counted and, on the last byte of a
// chunk, done, incomplete or error. Throughput is one byte per clock while
// the input queue holds a byte and the result queue has room or is popped,
// set by the parser state register that updates once per byte. Bytes pass
// from a 4-word input queue through the parser into a 2-word result queue;
// these queues let either side stall without stopping the other.
module rtsp_header_stream_parser import rhsp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [7:0]       data_byte,
	input  wire logic             chunk_end,
	input  wire logic             push,
	output logic                  full,
	output logic [7:0]            out_byte,
	output logic [2:0]            byte_role,
	output logic [1:0]            message_kind,
	output logic [VER_W-1:0]      major_version,
	output logic [VER_W-1:0]      minor_version,
	output logic [LEN_W-1:0]      body_length,
	output logic [LEN_W-1:0]      body_received,
	output logic [1:0]            chunk_status,
	output logic                  empty,
	input  wire logic             pop
);

	fq_t  fq;
	logic take;
	res_t res;

	// classify and queue incoming bytes
	rhsp_front u_front (
		.clk, .arst_n, .data_byte, .chunk_end, .push, .full, .fq, .take
	);

	// parse and queue results
	rhsp_back u_back (
		.clk, .arst_n, .fq, .take, .res, .empty, .pop
	);

	assign out_byte      = res.out_byte;
	assign byte_role     = res.byte_role;
	assign message_kind  = res.message_kind;
	assign major_version = res.major_version;
	assign minor_version = res.minor_version;
	assign body_length   = res.body_length;
	assign body_received = res.body_received;
	assign chunk_status  = res.chunk_status;

endmodule
`default_nettype wire
